@@ rtl/ffha_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the first-fit heap allocator.
package ffha_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic CFG_IDX_HEAP = 1'b0;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_FULL    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_ZERO    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    CO_HOLD,
    CO_INIT,
    CO_START,
    CO_STEP,
    CO_TAKE,
    CO_SPLIT,
    CO_MARK,
    CO_MERGE_NXT,
    CO_MERGE_PRV
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     is_free;
  } cell_cmd_t;

  typedef struct packed {
    logic hit;
    logic exact;
    logic live;
    logic nfree;
    logic pfree;
  } cell_stat_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_SCAN,
    FS_NXT,
    FS_PRV,
    FS_RESP
  } fsm_state_t;

endpackage

@@ rtl/ffha_in_if.sv @@
`timescale 1ns / 1ps
// Request channel: operation, size and address.
interface ffha_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [16:0] size;
  logic [15:0] address;

  modport source (output valid, op, size, address, input ready);
  modport sink (input valid, op, size, address, output ready);
endinterface

@@ rtl/ffha_out_if.sv @@
`timescale 1ns / 1ps
// Result channel: status and allocated block address.
interface ffha_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] block_address;

  modport source (output valid, status, block_address, input ready);
  modport sink (input valid, status, block_address, output ready);
endinterface

@@ rtl/ffha_cell.sv @@
`timescale 1ns / 1ps
// One segment table cell: holds a segment and trades it with its neighbours.
module ffha_cell #(
  parameter int              AW       = 16,
  parameter int              SW       = 17,
  parameter int              IDX      = 0,
  parameter logic [SW-1:0]   HEAP_RST = '0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffha_pkg::cell_cmd_t cmd,
  input  logic [SW-1:0]       req,
  input  logic [AW-1:0]       addr,
  input  logic [SW-1:0]       heap,
  input  logic                l_vld,
  input  logic [AW-1:0]       l_start,
  input  logic [SW-1:0]       l_size,
  input  logic                l_free,
  input  logic                l_tok,
  input  logic                r_vld,
  input  logic [AW-1:0]       r_start,
  input  logic [SW-1:0]       r_size,
  input  logic                r_free,
  input  logic                r_tok,
  output logic                vld,
  output logic [AW-1:0]       start,
  output logic [SW-1:0]       size,
  output logic                free,
  output logic                tok,
  output ffha_pkg::cell_stat_t stat
);

  logic          vld_r, vld_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic          free_r, free_nxt;
  logic          tok_r, tok_nxt;
  logic          seen_r, seen_nxt;

  always_comb begin
    vld_nxt   = vld_r;
    start_nxt = start_r;
    size_nxt  = size_r;
    free_nxt  = free_r;
    tok_nxt   = tok_r;
    seen_nxt  = seen_r;
    case (cmd.op)
      ffha_pkg::CO_INIT: begin
        vld_nxt   = (IDX == 0);
        start_nxt = '0;
        size_nxt  = heap;
        free_nxt  = 1'b1;
        tok_nxt   = 1'b0;
        seen_nxt  = 1'b1;
      end
      ffha_pkg::CO_START: begin
        tok_nxt  = (IDX == 0);
        seen_nxt = (IDX == 0);
      end
      ffha_pkg::CO_STEP: begin
        tok_nxt  = l_tok;
        seen_nxt = seen_r | l_tok;
      end
      ffha_pkg::CO_TAKE: begin
        if (tok_r) begin
          free_nxt = 1'b0;
        end
      end
      ffha_pkg::CO_SPLIT: begin
        if (tok_r) begin
          size_nxt = req;
          free_nxt = 1'b0;
        end else if (!seen_r) begin
          if (l_tok) begin
            vld_nxt   = 1'b1;
            start_nxt = l_start + req[AW-1:0];
            size_nxt  = l_size - req;
            free_nxt  = 1'b1;
          end else begin
            vld_nxt   = l_vld;
            start_nxt = l_start;
            size_nxt  = l_size;
            free_nxt  = l_free;
          end
        end
      end
      ffha_pkg::CO_MARK: begin
        if (tok_r) begin
          free_nxt = 1'b1;
        end
      end
      ffha_pkg::CO_MERGE_NXT: begin
        if (tok_r) begin
          size_nxt = size_r + r_size;
        end else if (!seen_r) begin
          vld_nxt   = r_vld;
          start_nxt = r_start;
          size_nxt  = r_size;
          free_nxt  = r_free;
        end
      end
      ffha_pkg::CO_MERGE_PRV: begin
        if (r_tok) begin
          size_nxt = size_r + r_size;
        end else if (tok_r || !seen_r) begin
          vld_nxt   = r_vld;
          start_nxt = r_start;
          size_nxt  = r_size;
          free_nxt  = r_free;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= (IDX == 0);
      start_r <= '0;
      size_r  <= HEAP_RST;
      free_r  <= 1'b1;
      tok_r   <= 1'b0;
      seen_r  <= 1'b1;
    end else begin
      vld_r   <= vld_nxt;
      start_r <= start_nxt;
      size_r  <= size_nxt;
      free_r  <= free_nxt;
      tok_r   <= tok_nxt;
      seen_r  <= seen_nxt;
    end
  end

  assign vld   = vld_r;
  assign start = start_r;
  assign size  = size_r;
  assign free  = free_r;
  assign tok   = tok_r;

  assign stat.hit   = tok_r & vld_r & (cmd.is_free ? (start_r == addr)
                                                   : (free_r && size_r >= req));
  assign stat.exact = tok_r & (size_r == req);
  assign stat.live  = tok_r & vld_r;
  assign stat.nfree = tok_r & r_vld & r_free;
  assign stat.pfree = r_tok & free_r;

endmodule

@@ rtl/ffha_cfg.sv @@
`timescale 1ns / 1ps
// APB register block holding the heap size.
module ffha_cfg #(
  parameter int            AW       = 16,
  parameter int            SW       = 17,
  parameter logic [SW-1:0] HEAP_RST = '0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffha_pkg::CFG_AW-1:0]   paddr,
  input  logic [ffha_pkg::CFG_DW-1:0]   pwdata,
  output logic [ffha_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output logic                          init,
  output logic [SW-1:0]                 heap_nxt
);

  localparam logic [SW-1:0] LIMIT = SW'(1) << AW;

  logic [SW-1:0]    heap_r;
  logic [SW+16:0]   wr_wide;
  logic [SW-1:0]    wr_val;
  logic [SW+31:0]   rd_wide;

  assign pready  = 1'b1;
  assign init    = psel & penable & pwrite & (paddr[2] == ffha_pkg::CFG_IDX_HEAP);
  assign wr_wide = {{SW{1'b0}}, pwdata[16:0]};

  always_comb begin
    wr_val = wr_wide[SW-1:0];
    if (wr_val == '0) begin
      wr_val = SW'(1);
    end else if (wr_val > LIMIT) begin
      wr_val = LIMIT;
    end
  end

  assign heap_nxt = init ? wr_val : heap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_r <= HEAP_RST;
    end else begin
      heap_r <= heap_nxt;
    end
  end

  assign rd_wide = {32'b0, heap_r};
  assign prdata  = (paddr[2] == ffha_pkg::CFG_IDX_HEAP) ? rd_wide[31:0] : '0;

endmodule

@@ rtl/first_fit_heap_allocator_top.sv @@
`timescale 1ns / 1ps
// Top level: segment cell chain, request sequencer and result register.
//
//  channel | direction | beat contents
//  in_ch   | sink      | op, size, address
//  out_ch  | source    | status, block_address
//  cfg_*   | APB slave | heap_size at offset 0
//
// An operation is accepted in the idle state; the token then walks the cell chain in
// the scan state to the matching segment. A free goes on through a merge-with-next and
// a merge-with-previous state; every operation ends in the result state. A miss scans
// past the last live segment; a zero-size allocate skips straight to the result.
// Reset loads one free segment of 65536 bytes; a heap_size write rebuilds it.
// The result cycle stalls while the output register still holds an untaken beat.
module first_fit_heap_allocator_top #(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ffha_in_if.sink                             in_ch,
  ffha_out_if.source                          out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ffha_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [ffha_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [ffha_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                                cfg_pready
);

  localparam int            AW       = ADDR_BITS;
  localparam int            SW       = (ADDR_BITS + 1 > 17) ? ADDR_BITS + 1 : 17;
  localparam int            N        = MAX_SEGMENTS;
  localparam logic [SW-1:0] LIMIT    = SW'(1) << AW;
  localparam logic [SW-1:0] HEAP_RST = (LIMIT < SW'(65536)) ? LIMIT : SW'(65536);

  logic          init;
  logic [SW-1:0] heap_nxt;

  ffha_cfg #(.AW(AW), .SW(SW), .HEAP_RST(HEAP_RST)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .init     (init),
    .heap_nxt (heap_nxt)
  );

  ffha_pkg::fsm_state_t state_r, state_nxt;
  logic                 is_free_r;
  logic [SW-1:0]        req_r;
  logic [AW-1:0]        addr_r;
  ffha_pkg::status_t    res_st_r;
  logic [AW-1:0]        res_addr_r;
  logic                 out_vld_r;
  ffha_pkg::status_t    out_st_r;
  logic [AW-1:0]        out_addr_r;

  ffha_pkg::cell_cmd_t  cmd;
  ffha_pkg::cell_op_t   fsm_op;
  logic                 res_we;
  ffha_pkg::status_t    res_st;
  logic [AW-1:0]        res_addr;

  logic                 c_vld   [N];
  logic [AW-1:0]        c_start [N];
  logic [SW-1:0]        c_size  [N];
  logic                 c_free  [N];
  logic                 c_tok   [N];
  ffha_pkg::cell_stat_t c_stat  [N];

  ffha_pkg::cell_stat_t bus;
  logic [AW-1:0]        tok_start;

  logic                 acc;
  logic                 zero_req;
  logic                 out_free;
  logic [SW+16:0]       size_wide;
  logic [AW+15:0]       addr_wide;
  logic [AW+15:0]       baddr_wide;

  assign cmd.op      = init ? ffha_pkg::CO_INIT : fsm_op;
  assign cmd.is_free = is_free_r;

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic          l_vld, l_free, l_tok, r_vld, r_free, r_tok;
    logic [AW-1:0] l_start, r_start;
    logic [SW-1:0] l_size, r_size;

    if (k == 0) begin : g_first
      assign l_vld   = 1'b0;
      assign l_start = '0;
      assign l_size  = '0;
      assign l_free  = 1'b0;
      assign l_tok   = 1'b0;
    end else begin : g_mid_l
      assign l_vld   = c_vld[k-1];
      assign l_start = c_start[k-1];
      assign l_size  = c_size[k-1];
      assign l_free  = c_free[k-1];
      assign l_tok   = c_tok[k-1];
    end

    if (k == N - 1) begin : g_last
      assign r_vld   = 1'b0;
      assign r_start = '0;
      assign r_size  = '0;
      assign r_free  = 1'b0;
      assign r_tok   = 1'b0;
    end else begin : g_mid_r
      assign r_vld   = c_vld[k+1];
      assign r_start = c_start[k+1];
      assign r_size  = c_size[k+1];
      assign r_free  = c_free[k+1];
      assign r_tok   = c_tok[k+1];
    end

    ffha_cell #(.AW(AW), .SW(SW), .IDX(k), .HEAP_RST(HEAP_RST)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .req     (req_r),
      .addr    (addr_r),
      .heap    (heap_nxt),
      .l_vld   (l_vld),
      .l_start (l_start),
      .l_size  (l_size),
      .l_free  (l_free),
      .l_tok   (l_tok),
      .r_vld   (r_vld),
      .r_start (r_start),
      .r_size  (r_size),
      .r_free  (r_free),
      .r_tok   (r_tok),
      .vld     (c_vld[k]),
      .start   (c_start[k]),
      .size    (c_size[k]),
      .free    (c_free[k]),
      .tok     (c_tok[k]),
      .stat    (c_stat[k])
    );
  end

  // token sits on one cell at most, so a plain OR picks its values
  always_comb begin
    bus       = '0;
    tok_start = '0;
    for (int k = 0; k < N; k++) begin
      bus       = bus | c_stat[k];
      tok_start = tok_start | (c_start[k] & {AW{c_tok[k]}});
    end
  end

  assign in_ch.ready = (state_r == ffha_pkg::FS_IDLE);
  assign acc         = in_ch.valid & in_ch.ready;
  assign zero_req    = !in_ch.op && (in_ch.size == '0);
  assign out_free    = !out_vld_r || out_ch.ready;
  assign size_wide   = {{SW{1'b0}}, in_ch.size};
  assign addr_wide   = {{AW{1'b0}}, in_ch.address};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffha_pkg::FS_IDLE: begin
        if (acc) begin
          state_nxt = zero_req ? ffha_pkg::FS_RESP : ffha_pkg::FS_SCAN;
        end
      end
      ffha_pkg::FS_SCAN: begin
        if (bus.hit) begin
          state_nxt = is_free_r ? ffha_pkg::FS_NXT : ffha_pkg::FS_RESP;
        end else if (!bus.live) begin
          state_nxt = ffha_pkg::FS_RESP;
        end
      end
      ffha_pkg::FS_NXT:  state_nxt = ffha_pkg::FS_PRV;
      ffha_pkg::FS_PRV:  state_nxt = ffha_pkg::FS_RESP;
      ffha_pkg::FS_RESP: begin
        if (out_free) begin
          state_nxt = ffha_pkg::FS_IDLE;
        end
      end
      default: state_nxt = ffha_pkg::FS_IDLE;
    endcase
  end

  always_comb begin
    fsm_op   = ffha_pkg::CO_HOLD;
    res_we   = 1'b0;
    res_st   = ffha_pkg::ST_OK;
    res_addr = '0;
    case (state_r)
      ffha_pkg::FS_IDLE: begin
        if (acc) begin
          res_we = 1'b1;
          res_st = ffha_pkg::ST_ZERO;
          if (!zero_req) begin
            fsm_op = ffha_pkg::CO_START;
          end
        end
      end
      ffha_pkg::FS_SCAN: begin
        if (bus.hit) begin
          res_we = 1'b1;
          if (is_free_r) begin
            fsm_op = ffha_pkg::CO_MARK;
          end else if (bus.exact) begin
            fsm_op   = ffha_pkg::CO_TAKE;
            res_addr = tok_start;
          end else if (c_vld[N-1]) begin
            res_st = ffha_pkg::ST_FULL;
          end else begin
            fsm_op   = ffha_pkg::CO_SPLIT;
            res_addr = tok_start;
          end
        end else if (!bus.live) begin
          res_we = 1'b1;
          res_st = is_free_r ? ffha_pkg::ST_UNKNOWN : ffha_pkg::ST_NOFIT;
        end else begin
          fsm_op = ffha_pkg::CO_STEP;
        end
      end
      ffha_pkg::FS_NXT: begin
        if (bus.nfree) begin
          fsm_op = ffha_pkg::CO_MERGE_NXT;
        end
      end
      ffha_pkg::FS_PRV: begin
        if (bus.pfree) begin
          fsm_op = ffha_pkg::CO_MERGE_PRV;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ffha_pkg::FS_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ffha_pkg::FS_RESP && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      is_free_r <= in_ch.op;
      req_r     <= size_wide[SW-1:0];
      addr_r    <= addr_wide[AW-1:0];
    end
    if (res_we) begin
      res_st_r   <= res_st;
      res_addr_r <= res_addr;
    end
    if (state_r == ffha_pkg::FS_RESP && out_free) begin
      out_st_r   <= res_st_r;
      out_addr_r <= res_addr_r;
    end
  end

  assign baddr_wide           = {16'b0, out_addr_r};
  assign out_ch.valid         = out_vld_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.block_address = baddr_wide[15:0];

endmodule
